// ----- design/ffba_pkg.sv -----
package ffba_pkg;

	// Default arena geometry.
	localparam int ARENA_BYTES_DEF  = 65536;
	localparam int HEADER_BYTES_DEF = 16;

	// Smallest block and the slack above which a free block is split.
	localparam int MIN_BLOCK   = 64;
	localparam int SPLIT_SLACK = 64;

	// Block kinds held in a boundary tag.
	typedef enum logic [1:0] {
		KIND_FREE = 2'd0,
		KIND_USED = 2'd1,
		KIND_TERM = 2'd2
	} kind_t;

	// Request codes.
	typedef enum logic {
		OP_ALLOC = 1'b0,
		OP_FREE  = 1'b1
	} op_t;

	// Result status codes.
	typedef enum logic {
		STAT_DONE  = 1'b0,
		STAT_NOFIT = 1'b1
	} stat_t;

	// Read and write strobes of the tag memory.
	typedef struct packed {
		logic we;
		logic re;
	} mem_cmd_t;

	// Sequencer states.
	typedef enum logic [4:0] {
		ST_CLEAR,
		ST_IDLE,
		ST_A_CHK,
		ST_A_NEW,
		ST_F_CHK,
		ST_F_PRV,
		ST_F_KILL,
		ST_F_INS,
		ST_F_HRD,
		ST_F_HEAD,
		ST_F_NXRD,
		ST_F_NX,
		ST_F_FBRD,
		ST_F_FBWR,
		ST_PS_RD,
		ST_PS_WR,
		ST_RM_NRD,
		ST_RM_NWR,
		ST_RM_PRD,
		ST_RM_PWR,
		ST_DONE
	} state_t;

endpackage

// ----- design/first_fit_block_allocator.sv -----
// Channel   Ports                                      Handshake
// request   op, req_size, block_addr                   start high while busy low
// result    result_addr, status, bytes_in_use          done high for one cycle
//
// After reset a clearing pass writes every tag, with busy high. An allocate walks the
// free list and splits the first block that fits or unlinks it; a miss ends the walk,
// and an empty list goes straight to done. A free merges the block into a free block
// before it or links it at the list head, then merges a free block after it; other
// frees are ignored. Each tag update is a read and a write on the single-port memory.
// The receiver cannot stall: done marks each result for one cycle and busy drops after it.
module first_fit_block_allocator import ffba_pkg::*; #(
	parameter int ARENA_BYTES  = ARENA_BYTES_DEF,
	parameter int HEADER_BYTES = HEADER_BYTES_DEF
) (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        start,
	input  logic        op,
	input  logic [15:0] req_size,
	input  logic [15:0] block_addr,
	output logic        busy,
	output logic        done,
	output logic [15:0] result_addr,
	output logic        status,
	output logic [16:0] bytes_in_use
);

	localparam int GRANULES = ARENA_BYTES / 8;
	localparam int IW       = $clog2(GRANULES);
	localparam int GW       = IW + 1;
	localparam int AW       = $clog2(ARENA_BYTES) + 1;
	localparam int W        = (AW + 1 > 18) ? AW + 1 : 18;
	localparam int END_OFF  = ARENA_BYTES - HEADER_BYTES;
	localparam int TERM_G   = END_OFF / 8;
	localparam int MIN_REQ  = MIN_BLOCK - HEADER_BYTES;

	localparam logic [GW-1:0] NIL = GW'(GRANULES);

	typedef struct packed {
		logic          live;
		kind_t         kind;
		logic [AW-1:0] at;
		logic [AW-1:0] size;
		logic [AW-1:0] back_size;
		logic [GW-1:0] next;
		logic [GW-1:0] prev;
	} tag_t;

	localparam int TW = $bits(tag_t);

	// Granule of a byte offset, and whether it lies inside the arena.
	function automatic logic [IW-1:0] gran(input logic [W-1:0] off);
		gran = off[IW+2:3];
	endfunction

	function automatic logic in_arena(input logic [W-1:0] off);
		in_arena = (off >> 3) < W'(GRANULES);
	endfunction

	state_t        state_q, state_d;
	state_t        ps_ret_q, rm_ret_q;
	logic [IW-1:0] clr_q;
	logic [GW-1:0] head_q, cur_q, steps_q, fb_q, rm_n_q, rm_p_q;
	logic [W-1:0]  need_q, h_q, look_q, ps_off_q;
	logic [AW-1:0] used_q, gsize_q, gps_q, fb_at_q, fb_size_q, ps_val_q;
	logic [15:0]   res_addr_q;
	logic          status_q;

	mem_cmd_t      mem_cmd;
	logic [IW-1:0] mem_addr;
	tag_t          mem_wdata, rd;
	logic [TW-1:0] rd_raw;

	ffba_tag_ram #(
		.DEPTH (GRANULES),
		.DW    (TW)
	) u_tag_ram (
		.clk   (clk),
		.cmd   (mem_cmd),
		.addr  (mem_addr),
		.wdata (mem_wdata),
		.rdata (rd_raw)
	);

	assign rd = tag_t'(rd_raw);

	// Request decode and tag checks.
	logic [W-1:0] req_w, need_new, free_h, rd_size_w, rd_at_w, rest_w, hoff_w;
	logic [W-1:0] pg_off, fb_end, ps_ofs_new;
	logic [AW-1:0] fb_size_merged;
	logic         is_alloc, free_ok, fit, split, walk_end;
	logic         g_used, has_prev, pg_hit, nx_hit, ps_hit;

	always_comb begin
		req_w     = W'(req_size);
		if (req_w < W'(MIN_REQ)) begin
			req_w = W'(MIN_REQ);
		end
		need_new  = (req_w + W'(HEADER_BYTES) + W'(7)) & ~W'(7);
		is_alloc  = (op_t'(op) == OP_ALLOC);
		free_h    = W'(block_addr) - W'(HEADER_BYTES);
		free_ok   = (block_addr >= 16'(HEADER_BYTES)) && in_arena(free_h);
		rd_size_w = W'(rd.size);
		rd_at_w   = W'(rd.at);
		fit       = rd_size_w >= need_q;
		split     = rd_size_w > need_q + W'(SPLIT_SLACK);
		rest_w    = rd_size_w - need_q;
		hoff_w    = rd_at_w + rest_w;
		walk_end  = (rd.next >= NIL) || (steps_q == GW'(GRANULES - 1));
		g_used    = rd.live && rd_at_w == h_q && rd.kind == KIND_USED;
		has_prev  = (rd.back_size != '0) && (W'(rd.back_size) <= h_q);
		pg_off    = h_q - W'(rd.back_size);
		pg_hit    = rd.live && rd_at_w == look_q && rd.kind == KIND_FREE;
		nx_hit    = rd.live && rd_at_w == look_q && rd.kind == KIND_FREE
		            && GW'(gran(look_q)) != fb_q;
		ps_hit    = rd.live && rd_at_w == ps_off_q;
		fb_end    = W'(fb_at_q) + W'(fb_size_q);
		fb_size_merged = fb_size_q + rd.size;
		ps_ofs_new = fb_end + W'(rd.size);
	end

	// Next state.
	always_comb begin
		state_d = state_q;
		case (state_q)
			ST_CLEAR: begin
				if (clr_q == IW'(GRANULES - 1)) state_d = ST_IDLE;
			end
			ST_IDLE: begin
				if (start) begin
					if (is_alloc) state_d = (head_q >= NIL) ? ST_DONE : ST_A_CHK;
					else          state_d = free_ok ? ST_F_CHK : ST_DONE;
				end
			end
			ST_A_CHK: begin
				if (fit)           state_d = split ? ST_A_NEW : ST_RM_NRD;
				else if (walk_end) state_d = ST_DONE;
			end
			ST_A_NEW:  state_d = ST_PS_RD;
			ST_F_CHK: begin
				if (!g_used) state_d = ST_DONE;
				else if (has_prev && in_arena(pg_off)) state_d = ST_F_PRV;
				else state_d = ST_F_INS;
			end
			ST_F_PRV:  state_d = pg_hit ? ST_F_KILL : ST_F_INS;
			ST_F_KILL: state_d = ST_PS_RD;
			ST_F_INS:  state_d = (head_q < NIL) ? ST_F_HRD : ST_F_NXRD;
			ST_F_HRD:  state_d = ST_F_HEAD;
			ST_F_HEAD: state_d = ST_F_NXRD;
			ST_F_NXRD: state_d = in_arena(fb_end) ? ST_F_NX : ST_DONE;
			ST_F_NX:   state_d = nx_hit ? ST_F_FBRD : ST_DONE;
			ST_F_FBRD: state_d = ST_F_FBWR;
			ST_F_FBWR: state_d = ST_RM_NRD;
			ST_PS_RD:  state_d = in_arena(ps_off_q) ? ST_PS_WR : ps_ret_q;
			ST_PS_WR:  state_d = ps_ret_q;
			ST_RM_NRD: state_d = (rm_n_q < NIL) ? ST_RM_NWR : ST_RM_PRD;
			ST_RM_NWR: state_d = ST_RM_PRD;
			ST_RM_PRD: state_d = (rm_p_q < NIL) ? ST_RM_PWR : rm_ret_q;
			ST_RM_PWR: state_d = rm_ret_q;
			ST_DONE:   state_d = ST_IDLE;
			default:   state_d = ST_IDLE;
		endcase
	end

	// Tag memory accesses of each state.
	always_comb begin
		mem_cmd   = '0;
		mem_addr  = '0;
		mem_wdata = rd;
		case (state_q)
			ST_CLEAR: begin
				mem_cmd.we = 1'b1;
				mem_addr   = clr_q;
				mem_wdata  = '0;
				if (clr_q == '0) begin
					mem_wdata.live = 1'b1;
					mem_wdata.kind = KIND_FREE;
					mem_wdata.size = AW'(END_OFF);
					mem_wdata.next = NIL;
					mem_wdata.prev = NIL;
				end else if (clr_q == IW'(TERM_G)) begin
					mem_wdata.live      = 1'b1;
					mem_wdata.kind      = KIND_TERM;
					mem_wdata.at        = AW'(END_OFF);
					mem_wdata.size      = AW'(1);
					mem_wdata.back_size = AW'(END_OFF);
					mem_wdata.next      = NIL;
					mem_wdata.prev      = NIL;
				end
			end
			ST_IDLE: begin
				mem_cmd.re = 1'b1;
				mem_addr   = is_alloc ? head_q[IW-1:0] : gran(free_h);
			end
			ST_A_CHK: begin
				if (fit) begin
					mem_cmd.we = 1'b1;
					mem_addr   = cur_q[IW-1:0];
					if (split) begin
						mem_wdata.size = AW'(rest_w);
					end else begin
						mem_wdata.kind = KIND_USED;
						mem_wdata.next = NIL;
						mem_wdata.prev = NIL;
					end
				end else if (!walk_end) begin
					mem_cmd.re = 1'b1;
					mem_addr   = rd.next[IW-1:0];
				end
			end
			ST_A_NEW: begin
				mem_cmd.we          = 1'b1;
				mem_addr            = gran(h_q);
				mem_wdata           = '0;
				mem_wdata.live      = 1'b1;
				mem_wdata.kind      = KIND_USED;
				mem_wdata.at        = AW'(h_q);
				mem_wdata.size      = AW'(need_q);
				mem_wdata.back_size = gsize_q;
				mem_wdata.next      = NIL;
				mem_wdata.prev      = NIL;
			end
			ST_F_CHK: begin
				mem_cmd.re = g_used && has_prev && in_arena(pg_off);
				mem_addr   = gran(pg_off);
			end
			ST_F_PRV: begin
				mem_cmd.we     = pg_hit;
				mem_addr       = gran(look_q);
				mem_wdata.size = rd.size + gsize_q;
			end
			ST_F_KILL: begin
				mem_cmd.we = 1'b1;
				mem_addr   = cur_q[IW-1:0];
				mem_wdata  = '0;
			end
			ST_F_INS: begin
				mem_cmd.we          = 1'b1;
				mem_addr            = cur_q[IW-1:0];
				mem_wdata.live      = 1'b1;
				mem_wdata.kind      = KIND_FREE;
				mem_wdata.at        = AW'(h_q);
				mem_wdata.size      = gsize_q;
				mem_wdata.back_size = gps_q;
				mem_wdata.next      = head_q;
				mem_wdata.prev      = NIL;
			end
			ST_F_HRD, ST_RM_NRD: begin
				mem_cmd.re = (rm_n_q < NIL);
				mem_addr   = rm_n_q[IW-1:0];
			end
			ST_F_HEAD: begin
				mem_cmd.we     = 1'b1;
				mem_addr       = rm_n_q[IW-1:0];
				mem_wdata.prev = cur_q;
			end
			ST_F_NXRD: begin
				mem_cmd.re = in_arena(fb_end);
				mem_addr   = gran(fb_end);
			end
			ST_F_NX: begin
				mem_cmd.we = nx_hit;
				mem_addr   = gran(look_q);
				mem_wdata  = '0;
			end
			ST_F_FBRD: begin
				mem_cmd.re = 1'b1;
				mem_addr   = fb_q[IW-1:0];
			end
			ST_F_FBWR: begin
				mem_cmd.we     = 1'b1;
				mem_addr       = fb_q[IW-1:0];
				mem_wdata.size = fb_size_q;
			end
			ST_PS_RD: begin
				mem_cmd.re = in_arena(ps_off_q);
				mem_addr   = gran(ps_off_q);
			end
			ST_PS_WR: begin
				mem_cmd.we          = ps_hit;
				mem_addr            = gran(ps_off_q);
				mem_wdata.back_size = ps_val_q;
			end
			ST_RM_NWR: begin
				mem_cmd.we     = 1'b1;
				mem_addr       = rm_n_q[IW-1:0];
				mem_wdata.prev = rm_p_q;
			end
			ST_RM_PRD: begin
				mem_cmd.re = (rm_p_q < NIL);
				mem_addr   = rm_p_q[IW-1:0];
			end
			ST_RM_PWR: begin
				mem_cmd.we     = 1'b1;
				mem_addr       = rm_p_q[IW-1:0];
				mem_wdata.next = rm_n_q;
			end
			default: begin
				mem_cmd = '0;
			end
		endcase
	end

	// Port outputs.
	always_comb begin
		busy         = (state_q != ST_IDLE);
		done         = (state_q == ST_DONE);
		result_addr  = res_addr_q;
		status       = status_q;
		bytes_in_use = 17'(used_q);
	end

	// Control registers.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_CLEAR;
			clr_q   <= '0;
			head_q  <= '0;
			used_q  <= '0;
		end else begin
			state_q <= state_d;
			if (state_q == ST_CLEAR) begin
				clr_q <= clr_q + IW'(1);
			end
			case (state_q)
				ST_A_CHK: begin
					if (fit && !split) used_q <= used_q + rd.size;
				end
				ST_A_NEW:  used_q <= used_q + AW'(need_q);
				ST_F_CHK: begin
					if (g_used) used_q <= used_q - rd.size;
				end
				ST_F_INS:  head_q <= cur_q;
				ST_RM_PRD: begin
					if (rm_p_q >= NIL) head_q <= rm_n_q;
				end
				default: begin
					head_q <= head_q;
				end
			endcase
		end
	end

	// Working registers of the sequencer.
	always_ff @(posedge clk) begin
		case (state_q)
			ST_IDLE: begin
				res_addr_q <= '0;
				status_q   <= (start && is_alloc && head_q >= NIL) ? STAT_NOFIT : STAT_DONE;
				need_q     <= need_new;
				h_q        <= free_h;
				steps_q    <= '0;
				cur_q      <= is_alloc ? head_q : GW'(gran(free_h));
			end
			ST_A_CHK: begin
				if (fit) begin
					if (split) begin
						h_q      <= hoff_w;
						gsize_q  <= AW'(rest_w);
						ps_off_q <= hoff_w + need_q;
						ps_val_q <= AW'(need_q);
						ps_ret_q <= ST_DONE;
						res_addr_q <= 16'(hoff_w + W'(HEADER_BYTES));
					end else begin
						rm_n_q   <= rd.next;
						rm_p_q   <= rd.prev;
						rm_ret_q <= ST_DONE;
						res_addr_q <= 16'(rd_at_w + W'(HEADER_BYTES));
					end
				end else if (walk_end) begin
					status_q <= STAT_NOFIT;
				end else begin
					cur_q   <= rd.next;
					steps_q <= steps_q + GW'(1);
				end
			end
			ST_F_CHK: begin
				gsize_q <= rd.size;
				gps_q   <= rd.back_size;
				look_q  <= pg_off;
			end
			ST_F_PRV: begin
				fb_q      <= GW'(gran(look_q));
				fb_at_q   <= rd.at;
				fb_size_q <= rd.size + gsize_q;
				ps_off_q  <= rd_at_w + W'(rd.size) + W'(gsize_q);
				ps_val_q  <= rd.size + gsize_q;
				ps_ret_q  <= ST_F_NXRD;
			end
			ST_F_INS: begin
				rm_n_q    <= head_q;
				fb_q      <= cur_q;
				fb_at_q   <= AW'(h_q);
				fb_size_q <= gsize_q;
			end
			ST_F_NXRD: begin
				look_q <= fb_end;
			end
			ST_F_NX: begin
				fb_size_q <= fb_size_merged;
				ps_off_q  <= ps_ofs_new;
				ps_val_q  <= fb_size_merged;
				ps_ret_q  <= ST_DONE;
				rm_n_q    <= rd.next;
				rm_p_q    <= rd.prev;
				rm_ret_q  <= ST_PS_RD;
			end
			default: begin
				need_q <= need_q;
			end
		endcase
	end

endmodule

// ----- design/ffba_tag_ram.sv -----
module ffba_tag_ram import ffba_pkg::*; #(
	parameter int DEPTH = 8192,
	parameter int DW    = 16
) (
	input  logic                     clk,
	input  mem_cmd_t                 cmd,
	input  logic [$clog2(DEPTH)-1:0] addr,
	input  logic [DW-1:0]            wdata,
	output logic [DW-1:0]            rdata
);

	logic [DW-1:0] mem [DEPTH];

	// Single port: one write or one registered read per cycle.
	always_ff @(posedge clk) begin
		if (cmd.we) begin
			mem[addr] <= wdata;
		end
		if (cmd.re) begin
			rdata <= mem[addr];
		end
	end

endmodule
